FILE: src/elst_pkg.sv
// Package for the early-late gate symbol timing block.
// Shared widths, register indexes and the sequencer state type.
// No dependencies.
package elst_pkg;
	localparam int MaxSps = 32;
	localparam int SampleBits = 16;
	localparam int WinDepth = 2 * MaxSps + 1;
	localparam int AddrBits = $clog2(WinDepth);
	localparam int SumBits = SampleBits + $clog2(MaxSps) + 1;
	localparam int SpsBits = 6;
	localparam int GainBits = 16;

	localparam logic [0:0] RegSps = 1'b0;
	localparam logic [0:0] RegGain = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_SUM = 8'b0000_0010,
		ST_MUL = 8'b0000_0100,
		ST_MIX = 8'b0000_1000,
		ST_DIV = 8'b0001_0000,
		ST_OUT = 8'b0010_0000,
		ST_WRITE = 8'b0100_0000,
		ST_RD = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic re_en;
		logic [AddrBits-1:0] raddr;
	} mem_rd_t;

	typedef struct packed {
		logic we;
		logic [AddrBits-1:0] waddr;
		logic [2*SampleBits-1:0] wdata;
	} mem_wr_t;
endpackage

FILE: src/elst_ram.sv
// Sample window storage: one write port, one registered read port.
// Depends on elst_pkg for the window depth and the port structs.
module elst_ram (
	input logic clk,
	input elst_pkg::mem_rd_t rd,
	input elst_pkg::mem_wr_t wr,
	output logic [2*elst_pkg::SampleBits-1:0] rdata
);
	logic [2*elst_pkg::SampleBits-1:0] mem [elst_pkg::WinDepth];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.waddr] <= wr.wdata;
		end
		if (rd.re_en) begin
			rdata <= mem[rd.raddr];
		end
	end
endmodule

FILE: src/early_late_symbol_timing_top.sv
// Early-late gate symbol timing synchronizer. The delay line sits in a
// circular buffer memory with a fill count; samples never written read as
// zero. Without a strobe each sample beat passes through the idle and read
// states. On a strobe the sequencer reads 2*sps window entries through the
// single memory read port (one per cycle), then multiplies, mixes and
// divides; the result write waits while an earlier result awaits ready.
// Depends on elst_pkg, elst_ram.
module early_late_symbol_timing_top (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input logic signed [15:0] sample_i,
	input logic signed [15:0] sample_q,
	output logic result_valid,
	input logic result_ready,
	output logic signed [15:0] symbol_i,
	output logic signed [15:0] symbol_q,
	output logic signed [31:0] loop_error,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data
);
	localparam int AB = elst_pkg::AddrBits;
	localparam int SB = elst_pkg::SumBits;
	localparam int DW = elst_pkg::WinDepth;

	elst_pkg::state_t state_q;
	elst_pkg::mem_rd_t rd;
	elst_pkg::mem_wr_t wr;
	logic [2*elst_pkg::SampleBits-1:0] rdata;

	logic [5:0] sps_cfg_q;
	logic [15:0] gain_q;
	logic [AB-1:0] head_q;
	logic [AB:0] fill_q;
	logic [7:0] cnt_q;
	logic signed [31:0] serr_q;
	logic signed [23:0] t_q;

	logic [5:0] sps;
	logic [6:0] idx_q;
	logic [6:0] rd_idx_q;
	logic rd_pend_q;
	logic signed [SB-1:0] early_q, late_q, sumq_q;
	logic signed [15:0] ctr_q;
	logic signed [47:0] prod_q;
	logic signed [31:0] e_q;
	logic [4:0] mix_step_q;
	logic signed [63:0] mix_q;
	logic [5:0] div_step_q;
	logic [SB-1:0] rem_i_q, rem_q_q, quo_i_q, quo_q_q;
	logic neg_i_q, neg_q_q;
	logic strobe;

	assign sps = (sps_cfg_q == 6'd0) ? 6'd1 : ((sps_cfg_q > 6'd32) ? 6'd32 : sps_cfg_q);
	assign strobe = (t_q[23] == 1'b0) && (cnt_q == t_q[23:16]);
	assign sample_ready = (state_q == elst_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	elst_ram u_ram (.clk(clk), .rd(rd), .wr(wr), .rdata(rdata));

	// position p of the delay line lives at head - p (mod depth)
	function automatic logic [AB-1:0] pos_addr(input logic [AB-1:0] h, input logic [6:0] p);
		logic [AB+1:0] a;
		a = {2'b0, h} + DW[AB+1:0] - {{(AB-5){1'b0}}, p};
		if (a >= DW[AB+1:0]) a = a - DW[AB+1:0];
		return a[AB-1:0];
	endfunction

	always_comb begin
		wr.we = sample_valid && sample_ready;
		wr.waddr = (head_q == AB'(DW - 1)) ? '0 : head_q + 1'b1;
		wr.wdata = {sample_i, sample_q};
		rd.re_en = (state_q == elst_pkg::ST_SUM) && (idx_q < {sps, 1'b0});
		rd.raddr = pos_addr(head_q, idx_q);
	end

	logic signed [SB-1:0] re_v, im_v;
	logic valid_v;
	logic signed [SB-1:0] d_v;
	logic signed [47:0] rnd_v;
	logic [SB-1:0] ni, nq;
	logic signed [32:0] half_v;
	always_comb begin
		valid_v = ({1'b0, rd_idx_q} < fill_q);
		re_v = valid_v ? SB'(signed'(rdata[31:16])) : '0;
		im_v = valid_v ? SB'(signed'(rdata[15:0])) : '0;
		d_v = early_q - late_q;
		rnd_v = (prod_q + 48'sd8192) >>> 14;
		ni = neg_i_q ? SB'(-early_q) : SB'(early_q);
		nq = neg_q_q ? SB'(-sumq_q) : SB'(sumq_q);
		half_v = (33'(serr_q) + 33'sd1) >>> 1;
	end

	logic signed [49:0] tw_v;
	assign tw_v = 50'(t_q) + (50'(signed'({1'b0, sps})) - 50'(signed'({1'b0, cnt_q}))) * 50'sd65536
		+ 50'(half_v);

	logic [SB:0] ri_sh, rq_sh;
	assign ri_sh = {rem_i_q, quo_i_q[SB-1]};
	assign rq_sh = {rem_q_q, quo_q_q[SB-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= elst_pkg::ST_IDLE;
			sps_cfg_q <= 6'd4;
			gain_q <= 16'd3277;
			head_q <= '0;
			fill_q <= '0;
			cnt_q <= '0;
			serr_q <= '0;
			t_q <= '0;
			result_valid <= 1'b0;
			idx_q <= '0;
			rd_idx_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					elst_pkg::RegSps: sps_cfg_q <= cfg_data[5:0];
					elst_pkg::RegGain: gain_q <= cfg_data;
					default: ;
				endcase
			end
			if (result_valid && result_ready) result_valid <= 1'b0;
			unique case (state_q)
				elst_pkg::ST_IDLE: begin
					if (sample_valid) begin
						head_q <= wr.waddr;
						if (fill_q != (AB+1)'(DW)) fill_q <= fill_q + 1'b1;
						state_q <= elst_pkg::ST_RD;
					end
				end
				elst_pkg::ST_RD: begin
					if (strobe) begin
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						early_q <= '0;
						late_q <= '0;
						sumq_q <= '0;
						state_q <= elst_pkg::ST_SUM;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= elst_pkg::ST_IDLE;
					end
				end
				elst_pkg::ST_SUM: begin
					rd_pend_q <= rd.re_en;
					rd_idx_q <= idx_q;
					if (rd.re_en) idx_q <= idx_q + 1'b1;
					if (rd_pend_q) begin
						if (rd_idx_q < {1'b0, sps}) begin
							late_q <= late_q + re_v;
						end else begin
							early_q <= early_q + re_v;
							sumq_q <= sumq_q + im_v;
						end
						if (rd_idx_q == {1'b0, sps}) ctr_q <= re_v[15:0];
					end
					if (!rd.re_en && !rd_pend_q) state_q <= elst_pkg::ST_MUL;
				end
				elst_pkg::ST_MUL: begin
					prod_q <= 48'(d_v) * 48'(ctr_q);
					mix_step_q <= '0;
					state_q <= elst_pkg::ST_MIX;
				end
				elst_pkg::ST_MIX: begin
					mix_step_q <= mix_step_q + 1'b1;
					unique case (mix_step_q)
						5'd0: begin
							if (rnd_v > 48'sh7FFF_FFFF) e_q <= 32'sh7FFF_FFFF;
							else if (rnd_v < -48'sh8000_0000) e_q <= -32'sh8000_0000;
							else e_q <= rnd_v[31:0];
						end
						5'd1: mix_q <= 64'(signed'({1'b0, 17'd65536 - {1'b0, gain_q}})) * 64'(serr_q);
						5'd2: mix_q <= mix_q + 64'(signed'({1'b0, gain_q})) * 64'(e_q);
						default: begin
							serr_q <= 32'((mix_q + 64'sd32768) >>> 16);
							neg_i_q <= early_q[SB-1];
							neg_q_q <= sumq_q[SB-1];
							state_q <= elst_pkg::ST_OUT;
						end
					endcase
				end
				elst_pkg::ST_OUT: begin
					// start restoring division on |sum| + sps/2
					quo_i_q <= ni + SB'(sps >> 1);
					quo_q_q <= nq + SB'(sps >> 1);
					rem_i_q <= '0;
					rem_q_q <= '0;
					div_step_q <= '0;
					if (tw_v > 50'sd8388607) t_q <= 24'sh7FFFFF;
					else if (tw_v < -50'sd8388608) t_q <= -24'sh800000;
					else t_q <= tw_v[23:0];
					state_q <= elst_pkg::ST_DIV;
				end
				elst_pkg::ST_DIV: begin
					if (div_step_q == 6'(SB)) begin
						state_q <= elst_pkg::ST_WRITE;
					end else begin
						div_step_q <= div_step_q + 1'b1;
						if (ri_sh >= (SB+1)'(sps)) begin
							rem_i_q <= SB'(ri_sh - (SB+1)'(sps));
							quo_i_q <= {quo_i_q[SB-2:0], 1'b1};
						end else begin
							rem_i_q <= ri_sh[SB-1:0];
							quo_i_q <= {quo_i_q[SB-2:0], 1'b0};
						end
						if (rq_sh >= (SB+1)'(sps)) begin
							rem_q_q <= SB'(rq_sh - (SB+1)'(sps));
							quo_q_q <= {quo_q_q[SB-2:0], 1'b1};
						end else begin
							rem_q_q <= rq_sh[SB-1:0];
							quo_q_q <= {quo_q_q[SB-2:0], 1'b0};
						end
					end
				end
				elst_pkg::ST_WRITE: begin
					if (!result_valid) begin
						symbol_i <= neg_i_q ? -quo_i_q[15:0] : quo_i_q[15:0];
						symbol_q <= neg_q_q ? -quo_q_q[15:0] : quo_q_q[15:0];
						loop_error <= serr_q;
						result_valid <= 1'b1;
						cnt_q <= 8'd1;
						state_q <= elst_pkg::ST_IDLE;
					end
				end
				default: state_q <= elst_pkg::ST_IDLE;
			endcase
		end
	end
endmodule
